// ----- design/bm25_pkg.sv -----
`default_nettype none
package bm25_pkg;

   localparam int SLOT_W    = 10;
   localparam int DOC_SLOTS = 1 << SLOT_W;
   localparam int Q_DEPTH   = 2;
   localparam int Q_AW      = $clog2(Q_DEPTH);
   localparam int CSR_AW    = 4;

   localparam logic [29:0] LN2_Q30   = 30'd744261118;
   localparam logic [20:0] IDF_FLOOR = 21'd7;
   localparam logic [12:0] ONE_Q12   = 13'd4096;
   localparam logic [27:0] AVG_ONE   = 28'd256;

   // register indexes (word address)
   localparam logic [1:0] REG_TOTAL_DOCS = 2'd0;
   localparam logic [1:0] REG_AVG_LEN    = 2'd1;
   localparam logic [1:0] REG_K1         = 2'd2;
   localparam logic [1:0] REG_B          = 2'd3;

   typedef struct packed {
      logic [20:0] total_docs;
      logic [27:0] avg_doc_len;
      logic [15:0] k1_gain;
      logic [12:0] b_weight;
   } cfg_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [15:0]       term_freq;
      logic [19:0]       doc_len;
      logic [20:0]       doc_freq;
      logic              new_query;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] out_slot;
      logic [31:0]       term_score;
      logic [31:0]       total_score;
      logic              first_hit;
   } rsp_type;

endpackage
`default_nettype wire

// ----- design/bm25_score_accumulator.sv -----
// Each request is scored from accept to result valid, with the tf divide skipped on a
// zero denominator; a new_query request first sweeps every slot mark clear. One request
// is worked at a time, so a new one is taken only once the last has left. The shared
// divider (46 + 21 steps) and shared log2 unit (two runs of 24 squaring steps) set the
// pace; a two-entry queue keeps accepting requests meanwhile, until it is full.
// Reset (synchronous, active high) loads register defaults and clears every slot mark.
`default_nettype none
module bm25_score_accumulator (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire bm25_pkg::req_type           req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output bm25_pkg::rsp_type                rsp_data,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [bm25_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import bm25_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    csr_wr;
   logic    q_valid, q_pop;
   req_type q_data;

   // Configuration: write in the access phase, no wait states.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_TOTAL_DOCS: cfg_in.total_docs  = csr_pwdata[20:0];
            REG_AVG_LEN:    cfg_in.avg_doc_len = csr_pwdata[27:0];
            REG_K1:         cfg_in.k1_gain     = csr_pwdata[15:0];
            REG_B:          cfg_in.b_weight    = csr_pwdata[12:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // Read back the addressed register, zero-extended.
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_TOTAL_DOCS: csr_prdata = {11'b0, cfg_ff.total_docs};
         REG_AVG_LEN:    csr_prdata = {4'b0, cfg_ff.avg_doc_len};
         REG_K1:         csr_prdata = {16'b0, cfg_ff.k1_gain};
         REG_B:          csr_prdata = {19'b0, cfg_ff.b_weight};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total_docs  <= '0;
         cfg_ff.avg_doc_len <= AVG_ONE;
         cfg_ff.k1_gain     <= 16'd4915;
         cfg_ff.b_weight    <= 13'd3072;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept and hold up to two requests so the input side waits only when full.
   bm25_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
   );

   // Back: score, accumulate into the slot store (unless the collection is empty), present the result.
   bm25_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

// ----- design/bm25_div.sv -----
`default_nettype none
module bm25_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [50:0] rem_init,
   input  wire logic [52:0] dvd_init,
   input  wire logic [50:0] divisor,
   input  wire logic [5:0]  iters,
   output logic             done,
   output logic [45:0]      quot
);
   logic [50:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic [52:0] dvd_ff, dvd_in;
   logic [45:0] q_ff, q_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [51:0] trial;
   logic        ge;

   // one restoring step per cycle
   always_comb begin
      trial  = {rem_ff, dvd_ff[52]};
      ge     = trial >= {1'b0, dsr_ff};
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      q_in   = q_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = rem_init;
         dvd_in  = dvd_init;
         dsr_in  = divisor;
         q_in    = '0;
         cnt_in  = iters;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? 51'(trial - {1'b0, dsr_ff}) : trial[50:0];
         dvd_in = {dvd_ff[51:0], 1'b0};
         q_in   = {q_ff[44:0], ge};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

// ----- design/bm25_log2.sv -----
`default_nettype none
module bm25_log2 (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [22:0] x,
   output logic             done,
   output logic [28:0]      result
);
   logic [30:0] m_ff, m_in;
   logic [4:0]  e_ff, e_in, lead;
   logic [23:0] frac_ff, frac_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [61:0] sq;
   logic [31:0] sq_hi;
   logic [30:0] x_wide;

   always_comb begin
      lead = '0;
      for (int i = 0; i < 23; i++) begin
         if (x[i]) lead = 5'(i);
      end
   end

   assign x_wide = {8'b0, x};
   assign sq     = m_ff * m_ff;
   assign sq_hi  = sq[61:30];

   // one squaring step per cycle, fraction bits come out msb first
   always_comb begin
      m_in    = m_ff;
      e_in    = e_ff;
      frac_in = frac_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         m_in    = x_wide << (5'd30 - lead);
         e_in    = lead;
         frac_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         m_in    = sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
         frac_in = {frac_ff[22:0], sq_hi[31]};
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == 5'd23) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      m_ff    <= m_in;
      e_ff    <= e_in;
      frac_ff <= frac_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = {e_ff, frac_ff};
endmodule
`default_nettype wire

// ----- design/bm25_front.sv -----
`default_nettype none
module bm25_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire bm25_pkg::req_type req_data,
   output logic                   q_valid,
   output bm25_pkg::req_type      q_data,
   input  wire logic              q_pop
);
   import bm25_pkg::*;

   req_type         entry_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [Q_AW:0]   cnt_ff, cnt_in;
   logic            push, pop;

   assign req_ready = cnt_ff != (Q_AW+1)'(Q_DEPTH);
   assign push      = req_valid && req_ready;
   assign q_valid   = cnt_ff != '0;
   assign pop       = q_pop && q_valid;
   assign q_data    = entry_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= req_data;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ----- design/bm25_back.sv -----
`default_nettype none
module bm25_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bm25_pkg::cfg_type cfg,
   input  wire logic              q_valid,
   input  wire bm25_pkg::req_type q_data,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output bm25_pkg::rsp_type      rsp_data
);
   import bm25_pkg::*;

   typedef enum logic [18:0] {
      S_IDLE    = 19'h00001,
      S_LOAD    = 19'h00002,
      S_P2      = 19'h00004,
      S_NDIV_GO = 19'h00008,
      S_NDIV_WT = 19'h00010,
      S_KN_LO   = 19'h00020,
      S_KN_HI   = 19'h00040,
      S_DEN     = 19'h00080,
      S_TDIV_GO = 19'h00100,
      S_TDIV_WT = 19'h00200,
      S_LOGA_GO = 19'h00400,
      S_LOGA_WT = 19'h00800,
      S_LOGB_GO = 19'h01000,
      S_LOGB_WT = 19'h02000,
      S_LN      = 19'h04000,
      S_SC      = 19'h08000,
      S_ACC     = 19'h10000,
      S_INIT    = 19'h20000,
      S_CLR     = 19'h40000
   } state_type;

   state_type            state_ff, state_in;
   req_type              job_ff;
   logic [41:0]          p_ff;
   logic [45:0]          norm_ff;
   logic [61:0]          kn_ff;
   logic [50:0]          den_ff;
   logic [52:0]          num_ff;
   logic [20:0]          tfpart_ff, idf_ff;
   logic [28:0]          la_ff, lb_ff;
   logic [31:0]          score_ff;
   // each word holds the slot's valid mark above its score
   logic [32:0]          score_mem [DOC_SLOTS];
   logic [32:0]          mem_q;
   logic [SLOT_W-1:0]    clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [27:0] avg_eff;
   logic [12:0] b_sat, bq;
   logic [40:0] pa_w;
   logic [32:0] blen_w;
   logic [41:0] p_sum_w;
   logic [22:0] kmul_op;
   logic [38:0] kmul_w;
   logic [16:0] k1p;
   logic [32:0] tfk_w;
   logic [28:0] ldiff;
   logic [58:0] lnprod;
   logic [20:0] ln_w;
   logic [41:0] sprod;
   logic [32:0] sum_w;
   logic        valid_eff, zero_docs, acc_go;
   logic        sweeping, sweep_last, mem_we;
   logic [SLOT_W-1:0] mem_wa;
   logic [32:0] mem_wd;

   logic        div_start, div_done, log_start, log_done;
   logic [50:0] div_rem, div_dsr;
   logic [52:0] div_dvd;
   logic [5:0]  div_iters;
   logic [45:0] div_quot;
   logic [22:0] log_x;
   logic [28:0] log_res;

   assign avg_eff = (cfg.avg_doc_len == '0) ? AVG_ONE : cfg.avg_doc_len;
   assign b_sat   = (cfg.b_weight > ONE_Q12) ? ONE_Q12 : cfg.b_weight;
   assign bq      = ONE_Q12 - b_sat;
   assign pa_w    = bq * avg_eff;
   assign blen_w  = b_sat * job_ff.doc_len;
   assign p_sum_w = p_ff + {1'b0, blen_w, 8'b0};
   assign kmul_op = (state_ff == S_KN_LO) ? norm_ff[22:0] : norm_ff[45:23];
   assign kmul_w  = cfg.k1_gain * kmul_op;
   assign k1p     = {1'b0, cfg.k1_gain} + 17'd4096;
   assign tfk_w   = job_ff.term_freq * k1p;
   assign ldiff   = la_ff - lb_ff;
   assign lnprod  = ldiff * LN2_Q30;
   assign ln_w    = (la_ff > lb_ff) ? lnprod[58:38] : '0;
   assign sprod   = idf_ff * tfpart_ff;
   assign sum_w   = {1'b0, mem_q[31:0]} + {1'b0, score_ff};
   assign zero_docs = cfg.total_docs == '0;
   assign valid_eff = mem_q[32];
   assign acc_go    = (state_ff == S_ACC) && (!rsp_valid_ff || rsp_ready);
   assign q_pop     = (state_ff == S_IDLE) && q_valid;

   // clear sweep over every slot: after reset and ahead of a new query
   assign sweeping   = (state_ff == S_INIT) || (state_ff == S_CLR);
   assign sweep_last = clr_ff == SLOT_W'(DOC_SLOTS - 1);
   assign clr_in     = sweeping ? clr_ff + 1'b1 : clr_ff;

   assign mem_we = sweeping || (acc_go && !zero_docs);
   assign mem_wa = sweeping ? clr_ff : job_ff.slot;
   assign mem_wd = sweeping ? '0 : {1'b1, rsp_in.total_score};

   // shared divider: norm first (46 steps), then tf part (21 steps)
   assign div_start = (state_ff == S_NDIV_GO) || ((state_ff == S_TDIV_GO) && den_ff != '0);
   assign div_rem   = (state_ff == S_NDIV_GO) ? '0 : {19'b0, num_ff[52:21]};
   assign div_dvd   = (state_ff == S_NDIV_GO) ? {p_ff, 11'b0} : {num_ff[20:0], 32'b0};
   assign div_dsr   = (state_ff == S_NDIV_GO) ? {23'b0, avg_eff} : den_ff;
   assign div_iters = (state_ff == S_NDIV_GO) ? 6'd46 : 6'd21;

   assign log_start = (state_ff == S_LOGA_GO) || (state_ff == S_LOGB_GO);
   assign log_x     = (state_ff == S_LOGA_GO) ? ({1'b0, cfg.total_docs, 1'b0} + 23'd2)
                                              : {1'b0, job_ff.doc_freq, 1'b1};

   bm25_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .rem_init(div_rem),
      .dvd_init(div_dvd), .divisor(div_dsr), .iters(div_iters),
      .done(div_done), .quot(div_quot)
   );

   bm25_log2 u_log2 (
      .clock(clock), .reset(reset), .start(log_start), .x(log_x),
      .done(log_done), .result(log_res)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT:    if (sweep_last) state_in = S_IDLE;
         S_IDLE:    if (q_valid) state_in = q_data.new_query ? S_CLR : S_LOAD;
         S_CLR:     if (sweep_last) state_in = S_LOAD;
         S_LOAD:    state_in = S_P2;
         S_P2:      state_in = S_NDIV_GO;
         S_NDIV_GO: state_in = S_NDIV_WT;
         S_NDIV_WT: if (div_done) state_in = S_KN_LO;
         S_KN_LO:   state_in = S_KN_HI;
         S_KN_HI:   state_in = S_DEN;
         S_DEN:     state_in = S_TDIV_GO;
         S_TDIV_GO: state_in = (den_ff == '0) ? S_LOGA_GO : S_TDIV_WT;
         S_TDIV_WT: if (div_done) state_in = S_LOGA_GO;
         S_LOGA_GO: state_in = S_LOGA_WT;
         S_LOGA_WT: if (log_done) state_in = S_LOGB_GO;
         S_LOGB_GO: state_in = S_LOGB_WT;
         S_LOGB_WT: if (log_done) state_in = S_LN;
         S_LN:      state_in = S_SC;
         S_SC:      state_in = S_ACC;
         S_ACC:     if (acc_go) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // result
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (acc_go) begin
         rsp_in.out_slot = job_ff.slot;
         if (zero_docs) begin
            rsp_in.term_score  = '0;
            rsp_in.total_score = valid_eff ? mem_q[31:0] : '0;
            rsp_in.first_hit   = 1'b0;
         end else begin
            rsp_in.term_score = score_ff;
            if (valid_eff) begin
               rsp_in.total_score = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
               rsp_in.first_hit   = 1'b0;
            end else begin
               rsp_in.total_score = score_ff;
               rsp_in.first_hit   = 1'b1;
            end
         end
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_LOAD) mem_q <= score_mem[job_ff.slot];
      if (mem_we) score_mem[mem_wa] <= mem_wd;
   end

   always_ff @(posedge clock) begin
      if (q_pop) job_ff <= q_data;
      if (state_ff == S_LOAD) p_ff <= {1'b0, pa_w};
      if (state_ff == S_P2) p_ff <= p_sum_w;
      if ((state_ff == S_NDIV_WT) && div_done) norm_ff <= div_quot;
      if (state_ff == S_KN_LO) kn_ff <= {23'b0, kmul_w};
      if (state_ff == S_KN_HI) kn_ff <= kn_ff + {kmul_w, 23'b0};
      if (state_ff == S_DEN) begin
         den_ff <= {19'b0, job_ff.term_freq, 16'b0} + {1'b0, kn_ff[61:12]};
         num_ff <= {tfk_w, 20'b0};
      end
      if ((state_ff == S_TDIV_GO) && den_ff == '0) tfpart_ff <= '0;
      if ((state_ff == S_TDIV_WT) && div_done) tfpart_ff <= div_quot[20:0];
      if ((state_ff == S_LOGA_WT) && log_done) la_ff <= log_res;
      if ((state_ff == S_LOGB_WT) && log_done) lb_ff <= log_res;
      if (state_ff == S_LN) idf_ff <= (ln_w > IDF_FLOOR) ? ln_w : IDF_FLOOR;
      if (state_ff == S_SC) score_ff <= {6'b0, sprod[41:16]};
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= S_INIT;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_NDIV_WT || state_ff == S_TDIV_WT))
      else $error("divider finished outside a wait state");
   a_log_done_waited: assert property (@(posedge clock) disable iff (reset)
      log_done |-> (state_ff == S_LOGA_WT || state_ff == S_LOGB_WT))
      else $error("log2 unit finished outside a wait state");
   a_acc_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      acc_go |=> rsp_valid_ff)
      else $error("result not presented after accumulate");
   a_empty_no_first: assert property (@(posedge clock) disable iff (reset)
      (acc_go && zero_docs) |=> !rsp_ff.first_hit && rsp_ff.term_score == '0)
      else $error("empty collection produced a score");
endmodule
`default_nettype wire

// ----- tb/sv/bm25_score_checker.sv -----
`timescale 1ns / 1ps
module bm25_score_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_ready,
   input  wire bm25_pkg::req_type           req_data,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   input  wire bm25_pkg::rsp_type           rsp_data,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic                        csr_pready,
   input  wire logic [bm25_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   output int                               fail_count,
   output int                               pending_count
);
   import bm25_pkg::*;

   typedef longint unsigned u64;

   cfg_type     cfg;
   logic [31:0] doc_score [DOC_SLOTS];
   bit          doc_hit [DOC_SLOTS];
   rsp_type     score_q [$];
   int          mismatches = 0;

   // log2 in Q8.24 by repeated squaring of a Q1.30 mantissa
   function automatic u64 fixed_log2(u64 x);
      u64 e;
      u64 m;
      u64 acc;
      if (x == 0) x = 1;
      e = 0;
      while (e < 40 && (x >> (e + 1)) != 0) e++;
      m = x << (30 - e);
      acc = e << 24;
      for (int i = 0; i < 24; i++) begin
         m = (m * m) >> 30;
         if (m >= (u64'(1) << 31)) begin
            m = m >> 1;
            acc = acc | (u64'(1) << (23 - i));
         end
      end
      return acc;
   endfunction

   function automatic u64 idf_weight(u64 n, u64 df);
      u64 la;
      u64 lb;
      u64 ln;
      la = fixed_log2(2 * n + 2);
      lb = fixed_log2(2 * df + 1);
      ln = 0;
      if (la > lb) ln = ((la - lb) * u64'(LN2_Q30)) >> 38;
      return (ln > u64'(IDF_FLOOR)) ? ln : u64'(IDF_FLOOR);
   endfunction

   function automatic u64 posting_score(u64 tf, u64 len, u64 df);
      u64 avg;
      u64 b;
      u64 k1;
      u64 p;
      u64 norm;
      u64 den;
      u64 tfpart;
      u64 s;
      avg = (cfg.avg_doc_len == 0) ? u64'(AVG_ONE) : u64'(cfg.avg_doc_len);
      b = (cfg.b_weight > ONE_Q12) ? u64'(ONE_Q12) : u64'(cfg.b_weight);
      k1 = u64'(cfg.k1_gain);
      p = (u64'(ONE_Q12) - b) * avg + 256 * b * len;
      norm = (p * 16) / avg;
      den = (tf << 16) + ((k1 * norm) >> 12);
      if (den == 0) return 0;
      tfpart = ((tf * (k1 + u64'(ONE_Q12))) << 20) / den;
      s = (idf_weight(u64'(cfg.total_docs), df) * tfpart) >> 16;
      return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
   endfunction

   function automatic rsp_type score_posting(req_type r);
      rsp_type o;
      u64      sum;
      if (r.new_query) foreach (doc_hit[i]) doc_hit[i] = 1'b0;
      o.out_slot = r.slot;
      o.first_hit = 1'b0;
      if (cfg.total_docs == 0) begin
         o.term_score = '0;
         o.total_score = doc_hit[r.slot] ? doc_score[r.slot] : 32'd0;
      end else begin
         o.term_score = 32'(posting_score(r.term_freq, r.doc_len, r.doc_freq));
         if (doc_hit[r.slot]) begin
            sum = u64'(doc_score[r.slot]) + u64'(o.term_score);
            o.total_score = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(sum);
         end else begin
            o.total_score = o.term_score;
            o.first_hit = 1'b1;
            doc_hit[r.slot] = 1'b1;
         end
         doc_score[r.slot] = o.total_score;
      end
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg.total_docs = '0;
         cfg.avg_doc_len = AVG_ONE;
         cfg.k1_gain = 16'd4915;
         cfg.b_weight = 13'd3072;
         foreach (doc_hit[i]) doc_hit[i] = 1'b0;
         score_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_TOTAL_DOCS: cfg.total_docs = csr_pwdata[20:0];
               REG_AVG_LEN:    cfg.avg_doc_len = csr_pwdata[27:0];
               REG_K1:         cfg.k1_gain = csr_pwdata[15:0];
               REG_B:          cfg.b_weight = csr_pwdata[12:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            score_q.insert(score_q.size(), score_posting(req_data));
         if (rsp_valid && rsp_ready) begin
            if (score_q.size() == 0) begin
               $error("unexpected result for slot %0d", rsp_data.out_slot);
               mismatches++;
            end else begin
               want = score_q.pop_front();
               if (rsp_data.out_slot !== want.out_slot) begin
                  $error("out_slot: expected %0d, actual %0d", want.out_slot,
                         rsp_data.out_slot);
                  mismatches++;
               end
               if (rsp_data.term_score !== want.term_score) begin
                  $error("term_score: expected %0h, actual %0h", want.term_score,
                         rsp_data.term_score);
                  mismatches++;
               end
               if (rsp_data.total_score !== want.total_score) begin
                  $error("total_score: expected %0h, actual %0h", want.total_score,
                         rsp_data.total_score);
                  mismatches++;
               end
               if (rsp_data.first_hit !== want.first_hit) begin
                  $error("first_hit: expected %0d, actual %0d", want.first_hit,
                         rsp_data.first_hit);
                  mismatches++;
               end
            end
         end
      end
      fail_count = mismatches;
      pending_count = score_q.size();
   end

endmodule

// ----- tb/sv/bm25_score_accumulator_tb.sv -----
`timescale 1ns / 1ps
module bm25_score_accumulator_tb;
   import bm25_pkg::*;

   // cycles without any accepted request or result before the run is called dead
   localparam int STALL_LIMIT = 10000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;
   int                fail_count;
   int                pending_count;
   int                quiet_cycles = 0;
   bit                steady = 1'b0;   // no idling on either side while set

   bm25_score_accumulator uut (.*);

   bm25_score_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_psel, .csr_penable, .csr_pwrite, .csr_pready, .csr_paddr,
      .csr_pwdata, .fail_count, .pending_count
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // result side: drop ready about 22 percent of the time unless running steady
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 22);
   end

   // watchdog: advance while nothing moves, end the run at the limit
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Present one request and hold it until accepted. A random gap drops valid
   // first; back-to-back requests keep valid high with no dip.
   task automatic send_posting(req_type r);
      if (!steady && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 22);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every outstanding result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; pready is always high.
   // The bus is left selected; load_cfg releases it after the last write.
   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
   endtask

   task automatic load_cfg(logic [31:0] n, logic [31:0] avg, logic [31:0] k1,
                           logic [31:0] b);
      drain();
      csr_write(REG_TOTAL_DOCS, n);
      csr_write(REG_AVG_LEN, avg);
      csr_write(REG_K1, k1);
      csr_write(REG_B, b);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic req_type posting(int slot, int tf, int len, int df, bit nq);
      req_type r;
      r.slot = SLOT_W'(slot);
      r.term_freq = 16'(tf);
      r.doc_len = 20'(len);
      r.doc_freq = 21'(df);
      r.new_query = nq;
      return r;
   endfunction

   // Random posting: mostly a few hot slots so scores accumulate, with full-range
   // values mixed in so every field bit toggles.
   function automatic req_type random_posting();
      req_type r;
      r.slot = ($urandom_range(99) < 60) ? SLOT_W'($urandom_range(15))
                                         : SLOT_W'($urandom);
      r.term_freq = ($urandom_range(1) == 1) ? 16'($urandom_range(20)) : 16'($urandom);
      r.doc_len = ($urandom_range(1) == 1) ? 20'($urandom_range(2000)) : 20'($urandom);
      r.doc_freq = ($urandom_range(1) == 1) ? 21'($urandom_range(1, 1000))
                                            : 21'($urandom);
      r.new_query = ($urandom_range(99) < 4);
      return r;
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty collection under reset defaults: nothing accumulates
      send_posting(posting(3, 5, 100, 10, 1'b1));
      send_posting(posting(3, 65535, 1048575, 1, 1'b0));
      send_posting(posting(1023, 1, 0, 2097151, 1'b0));

      // full collection, zero average length
      load_cfg(1048576, 0, 4915, 3072);
      send_posting(posting(0, 0, 0, 0, 1'b1));
      send_posting(posting(1023, 65535, 1048575, 1, 1'b0));
      send_posting(posting(1023, 1, 0, 1048576, 1'b0));
      send_posting(posting(0, 7, 300, 2097151, 1'b0));
      send_posting(posting(512, 3, 512, 0, 1'b0));
      send_posting(posting(0, 2, 10, 50, 1'b1));

      // one document, longest average, largest k1, b above one
      load_cfg(1, 268435455, 65535, 8191);
      send_posting(posting(7, 65535, 1048575, 0, 1'b0));
      send_posting(posting(7, 1, 1, 1, 1'b0));
      send_posting(posting(8, 12, 0, 2, 1'b0));

      // smallest average, k1 and b zero: zero denominator when tf is zero
      load_cfg(1048576, 1, 0, 0);
      send_posting(posting(9, 0, 0, 1, 1'b0));
      send_posting(posting(9, 65535, 1048575, 1, 1'b0));
      send_posting(posting(10, 100, 5, 999, 1'b0));

      // hammer one slot with maximal scores until the accumulator saturates
      load_cfg(1048576, 256, 65535, 4096);
      steady = 1'b1;
      send_posting(posting(5, 65535, 0, 1, 1'b1));
      repeat (320) send_posting(posting(5, 65535, 0, $urandom_range(1, 3), 1'b0));
      steady = 1'b0;

      // random phases with random register settings
      for (int ph = 0; ph < 8; ph++) begin
         load_cfg($urandom_range(1) ? $urandom_range(1, 5000) : $urandom,
                  $urandom_range(1) ? $urandom_range(0, 100000) : $urandom,
                  $urandom_range(1) ? $urandom_range(0, 8192) : $urandom,
                  $urandom_range(1) ? $urandom_range(0, 4096) : $urandom);
         steady = (ph == 3);
         repeat (120) send_posting(random_posting());
      end
      steady = 1'b0;

      // default tuning, then back to an empty collection
      load_cfg(100000, 256, 4915, 3072);
      repeat (50) send_posting(random_posting());
      load_cfg(0, 256, 4915, 3072);
      repeat (20) send_posting(random_posting());

      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
